/* sv/kedt_pkg.sv */
// shared constants for the keyed event debounce table
package kedt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int TIME_BITS_DEF = 48;

    localparam logic [31:0] DEBOUNCE_RST = 32'd1000;
    localparam logic [7:0]  DELETE_RST   = 8'd3;

    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELETE   = 1'd1;

    // operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_CLOSE   = 2'd1;
    localparam logic [1:0] OP_DELETE  = 2'd2;
    localparam logic [1:0] OP_PROCESS = 2'd3;

endpackage

/* sv/kedt_if.sv */
// valid/ready channel interfaces for input and result words
interface kedt_in_if #(
    parameter int KEY_BITS  = kedt_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = kedt_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [KEY_BITS-1:0]  key;
    logic [7:0]           ev_code;
    logic [TIME_BITS-1:0] now_time;

    modport source (output valid, output operation, output key, output ev_code,
                    output now_time, input ready);
    modport sink (input valid, input operation, input key, input ev_code,
                  input now_time, output ready);
endinterface

interface kedt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] entry_key;
    logic [7:0]  entry_event;
    logic        carries_entry;
    logic        last_of_run;
    logic [4:0]  flushed_total;
    logic [4:0]  pending_total;

    modport source (output valid, output entry_key, output entry_event,
                    output carries_entry, output last_of_run, output flushed_total,
                    output pending_total, input ready);
    modport sink (input valid, input entry_key, input entry_event,
                  input carries_entry, input last_of_run, input flushed_total,
                  input pending_total, output ready);
endinterface

/* sv/keyed_event_debounce_table.sv */
// keyed event debounce table top level
//
//  channel   dir  handshake       contents
//  in_ch     in   valid/ready     operation, key, ev_code, now_time
//  out_ch    out  valid/ready     entry_key, entry_event, carries_entry, last_of_run,
//                                 flushed_total, pending_total
//  cfg       in   i_cfg_we        i_cfg_idx, i_cfg_data
//
// each word scans the slot memory one entry per cycle while the scan is not stalled,
// through a single port with a registered read, then a write-back or final state.
// a flushed entry waits in a one-entry holding register so the final one can be flagged;
// the scan stalls while the holding and output registers are both full.
// reset clears valid bits and the active count directly; no clearing pass.
// a stalled output holds the scan until the result word is taken.
module keyed_event_debounce_table #(
    parameter int SLOTS     = kedt_pkg::SLOTS_DEF,
    parameter int KEY_BITS  = kedt_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = kedt_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kedt_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [kedt_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    kedt_in_if.sink                              in_ch,
    kedt_out_if.source                           out_ch
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = KEY_BITS + 8 + TIME_BITS + 1;
    localparam int AW = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_LAST  = 4'b1000
    } t_state;

    // slot memory: {key, event, time, forced}
    logic [MW-1:0] mem [SLOTS];
    logic [MW-1:0] r_rd;
    logic [SLOTS-1:0] r_valid;

    t_state r_state;
    logic [IW:0] r_ra;          // read address counter
    logic        r_rv;          // read data valid this cycle
    logic [IW-1:0] r_ri;        // index of r_rd
    logic [31:0] r_deb;
    logic [7:0]  r_del;
    logic [1:0]  r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [7:0] r_ev;
    logic [TIME_BITS-1:0] r_now;
    logic r_hit;
    logic [IW-1:0] r_hidx;
    logic [MW-1:0] r_hdat;
    logic r_free;
    logic [IW-1:0] r_fidx;
    logic [IW-1:0] r_oidx;
    logic [TIME_BITS-1:0] r_otime;
    logic [CW-1:0] r_act;
    logic [CW-1:0] r_nflush;

    // holding register for the most recent flushed entry
    logic r_pv;
    logic [31:0] r_pkey;
    logic [7:0] r_pev;
    logic [4:0] r_ppnd;

    // output register
    logic r_ov;
    logic [31:0] r_okey;
    logic [7:0] r_oev;
    logic r_ocar, r_olast;
    logic [4:0] r_oflt, r_opnd;

    logic rd_en;
    logic [KEY_BITS-1:0] m_key;
    logic [7:0] m_ev;
    logic [TIME_BITS-1:0] m_time;
    logic m_forced;
    logic m_vld;
    logic m_ready;
    logic [TIME_BITS-1:0] age;
    logic we;
    logic [IW-1:0] wa;
    logic [MW-1:0] wd;
    logic out_free;
    logic stall;
    logic flush_go;
    logic ov_load;

    assign out_free = !r_ov || out_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);

    // read while scanning, stall process scan if a ready entry cannot be held
    assign {m_key, m_ev, m_time, m_forced} = r_rd;
    assign m_vld = r_valid[r_ri];
    assign age = r_now - m_time;
    assign m_ready = m_vld && (m_forced ||
                     (m_time != '0 && AW'(age) >= AW'(r_deb)));
    assign stall = r_rv && (r_op == kedt_pkg::OP_PROCESS) && m_ready && r_pv && !out_free;
    assign flush_go = (r_state == S_SCAN) && r_rv && (r_op == kedt_pkg::OP_PROCESS) &&
                      m_ready && !stall;
    assign ov_load = (flush_go && r_pv) || (r_state == S_LAST && out_free);
    assign rd_en = (r_state == S_SCAN) && (r_ra < (IW+1)'(SLOTS)) && !stall;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[r_ra[IW-1:0]];
        end
        if (we) begin
            mem[wa] <= wd;
        end
    end

    // write-back data for add, close and delete
    always_comb begin
        we = (r_state == S_WRITE) && (r_hit || r_op != kedt_pkg::OP_CLOSE);
        wa = r_hit ? r_hidx : (r_free ? r_fidx : r_oidx);
        wd = r_hdat;
        if (r_hit) begin
            case (r_op)
                kedt_pkg::OP_ADD: begin
                    wd[TIME_BITS:1] = r_now;
                    if (r_ev != r_del) begin
                        wd[TIME_BITS+8:TIME_BITS+1] = r_ev;
                    end
                end
                kedt_pkg::OP_CLOSE: begin
                    wd[TIME_BITS:1] = '0;
                    wd[0] = 1'b1;
                end
                default: begin
                    wd[TIME_BITS+8:TIME_BITS+1] = r_del;
                    wd[TIME_BITS:1] = '0;
                    wd[0] = 1'b1;
                end
            endcase
        end else if (r_op == kedt_pkg::OP_ADD) begin
            wd = {r_key, r_ev, r_now, 1'b0};
        end else begin
            wd = {r_key, r_del, {TIME_BITS{1'b0}}, 1'b1};
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_act <= '0;
            r_ov <= 1'b0;
            r_rv <= 1'b0;
            r_pv <= 1'b0;
            r_deb <= kedt_pkg::DEBOUNCE_RST;
            r_del <= kedt_pkg::DELETE_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kedt_pkg::REG_DEBOUNCE: r_deb <= i_cfg_data;
                    kedt_pkg::REG_DELETE:   r_del <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // output valid: load a new word or drop the taken one
            if (ov_load) begin
                r_ov <= 1'b1;
            end else if (out_ch.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_op <= in_ch.operation;
                        r_key <= in_ch.key;
                        r_ev <= in_ch.ev_code;
                        r_now <= in_ch.now_time;
                        r_ra <= '0;
                        r_rv <= 1'b0;
                        r_hit <= 1'b0;
                        r_free <= 1'b0;
                        r_oidx <= '0;
                        r_nflush <= '0;
                        r_pv <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_ra <= r_ra + (IW+1)'(1);
                        r_ri <= r_ra[IW-1:0];
                    end
                    r_rv <= rd_en || stall;
                    if (flush_go) begin
                        r_valid[r_ri] <= 1'b0;
                        r_act <= r_act - CW'(1);
                        r_nflush <= r_nflush + CW'(1);
                        // previous held entry moves to the output register
                        if (r_pv) begin
                            r_okey <= r_pkey;
                            r_oev <= r_pev;
                            r_ocar <= 1'b1;
                            r_olast <= 1'b0;
                            r_oflt <= '0;
                            r_opnd <= r_ppnd;
                        end
                        r_pv <= 1'b1;
                        r_pkey <= 32'(m_key);
                        r_pev <= m_ev;
                        r_ppnd <= 5'(r_act - CW'(1));
                    end else if (r_rv && r_op != kedt_pkg::OP_PROCESS) begin
                        if (m_vld && m_key == r_key && !r_hit) begin
                            r_hit <= 1'b1;
                            r_hidx <= r_ri;
                            r_hdat <= r_rd;
                        end
                        if (!m_vld && !r_free) begin
                            r_free <= 1'b1;
                            r_fidx <= r_ri;
                        end
                        if (m_vld && (r_ri == '0 || m_time < r_otime)) begin
                            r_oidx <= r_ri;
                            r_otime <= m_time;
                        end
                    end
                    if (!rd_en && r_ra == (IW+1)'(SLOTS) && !stall) begin
                        r_state <= (r_op == kedt_pkg::OP_PROCESS) ? S_LAST : S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (!r_hit && r_op != kedt_pkg::OP_CLOSE) begin
                        r_valid[wa] <= 1'b1;
                        if (r_free) begin
                            r_act <= r_act + CW'(1);
                        end
                    end
                    r_state <= S_IDLE;
                end
                S_LAST: begin
                    // final word: held entry flagged last, or the empty word
                    if (out_free) begin
                        r_okey <= r_pv ? r_pkey : 32'd0;
                        r_oev <= r_pv ? r_pev : 8'd0;
                        r_ocar <= r_pv;
                        r_olast <= 1'b1;
                        r_oflt <= 5'(r_nflush);
                        r_opnd <= r_pv ? r_ppnd : 5'(r_act);
                        r_pv <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.entry_key = r_okey;
    assign out_ch.entry_event = r_oev;
    assign out_ch.carries_entry = r_ocar;
    assign out_ch.last_of_run = r_olast;
    assign out_ch.flushed_total = r_oflt;
    assign out_ch.pending_total = r_opnd;
endmodule

/* sv/kedt_checker.sv */
// port-level checks for the keyed event debounce table
module kedt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_carries,
    input logic out_last,
    input logic [4:0] out_flushed
);
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_carries |-> out_last && out_flushed == 5'd0)
        else $error("empty result not final");
    a_flushed_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_last |-> out_flushed == 5'd0)
        else $error("flush count on non-final result");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");
endmodule

bind keyed_event_debounce_table kedt_checker u_kedt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_carries(out_ch.carries_entry), .out_last(out_ch.last_of_run),
    .out_flushed(out_ch.flushed_total)
);
